// ===== hw/rtl/swtq_pkg.sv =====
package swtq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_UNWAIT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_WOKEN = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  localparam logic [1:0] REG_MS_PER_TICK = 2'd0;
  localparam logic [1:0] REG_RECAL       = 2'd1;
  localparam logic [1:0] REG_HPET_EN     = 2'd2;

  localparam int NsPerMs = 1000000;

  // result item, kind in the low bits
  typedef struct packed {
    logic        last;
    logic [63:0] now_ms;
    logic        queue_full;
    logic        timed_out;
    logic [15:0] woken_task;
    kind_t       kind;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/swtq_div.sv =====
// divide by one million, one byte of dividend at a time, by reciprocal multiply
module swtq_div (
  input  logic               clk,
  input  logic               rst,
  input  swtq_pkg::div_req_t req,
  output swtq_pkg::div_rsp_t rsp
);
  import swtq_pkg::*;

  localparam logic [19:0] Divisor = 20'(NsPerMs);
  // 2^48 / 1e6 rounded up, exact for every 28-bit partial dividend
  localparam logic [28:0] Recip = 29'd281474977;

  logic [63:0] src;
  logic [63:0] quo;
  logic [19:0] rem;
  logic [27:0] part;
  logic [7:0]  qd;
  logic [2:0]  cnt;
  logic        phase;
  logic        busy;
  logic        done;
  logic [56:0] prod;
  logic [27:0] back;

  // partial dividend is the running remainder with the next byte appended
  assign prod = 57'({rem, src[63:56]}) * 57'(Recip);
  assign back = 28'(qd) * 28'(Divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        src   <= req.dividend;
        quo   <= '0;
        rem   <= '0;
        cnt   <= 3'd7;
        phase <= 1'b0;
      end else if (busy) begin
        if (!phase) begin
          part  <= {rem, src[63:56]};
          qd    <= prod[55:48];
          phase <= 1'b1;
        end else begin
          rem   <= part[19:0] - back[19:0];
          quo   <= {quo[55:0], qd};
          src   <= {src[55:0], 8'd0};
          cnt   <= cnt - 3'd1;
          phase <= 1'b0;
          if (cnt == 3'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy)) else $error("divider done without work");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && !(phase && cnt == 3'd0) |=> busy) else $error("divider stopped early");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < Divisor) else $error("remainder out of range");

endmodule

// ===== hw/rtl/sorted_wake_timer_queue.sv =====
// Sorted wake-timer queue: a millisecond clock plus up to CAPACITY waiters held
// in wake-time order in a slot memory walked slot by slot by a single
// compare/move sequencer. Unwait moves the later slots down for each entry it
// removes. Recalibration on a tick runs the byte-wise reciprocal divide by one
// million. Results leave through a one-item output register, and the input
// stays blocked until the last result has left. A tick emits each woken task
// (kind 1) and then a tick-done item; tlast marks the final result.
module sorted_wake_timer_queue #(
  parameter int CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[1:0], task_id[17:2], wake_time[81:18], hpet_nanos[145:82], zero fill
  input  logic [151:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // kind[1:0], woken_task[17:2], timed_out[18], queue_full[19], now_ms[83:20]
  output logic [87:0]  m_tdata,
  output logic         m_tlast
);
  import swtq_pkg::*;

  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIND, ST_SHIFT_RD, ST_SHIFT_WR, ST_PUT, ST_SCAN, ST_DROP_RD,
    ST_DROP_WR, ST_TICK, ST_DIV, ST_HEAD, ST_HEAD_CHK, ST_EMIT
  } state_t;

  logic [63:0] mem_wake [CAPACITY];
  logic [15:0] mem_task [CAPACITY];

  logic [9:0]  ms_per_tick;
  logic [15:0] recal_interval_ms;
  logic        hpet_enable;

  state_t      state;
  op_t         op;
  logic [15:0] task_id;
  logic [63:0] wake;
  logic [63:0] nanos;
  logic [CntW-1:0] count;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] pos;
  logic [63:0] clock_ms;
  logic [63:0] last_nanos;
  logic [63:0] last_recal_ms;
  logic        found;
  logic        after_tick;

  logic        rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [63:0] rd_wake;
  logic [15:0] rd_task;
  logic        wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [63:0] wr_wake;
  logic [15:0] wr_task;

  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [63:0] elapsed_ms;

  result_t     res;
  logic        out_valid;
  logic        res_put;
  logic        res_taken;
  logic [63:0] tick_clock;

  swtq_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign elapsed_ms = drsp.quotient;
  assign tick_clock = clock_ms + 64'(ms_per_tick);

  // output register is full while more results were loaded than taken
  assign out_valid = res_put ^ res_taken;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_wake[wr_addr] <= wr_wake;
      mem_task[wr_addr] <= wr_task;
    end
    if (rd_en) begin
      rd_wake <= mem_wake[rd_addr];
      rd_task <= mem_task[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_per_tick       <= 10'd1;
      recal_interval_ms <= 16'd1000;
      hpet_enable       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MS_PER_TICK: ms_per_tick <= cfg_data[9:0];
        REG_RECAL:       recal_interval_ms <= cfg_data;
        REG_HPET_EN:     hpet_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_taken <= 1'b0;
    end else if (out_valid && m_tready) begin
      res_taken <= ~res_taken;
    end
  end

  assign s_tready = (state == ST_IDLE) && !out_valid;

  // memory port and divider start control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[IdxW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx[IdxW-1:0];
    wr_wake = wake;
    wr_task = task_id;
    dreq.start    = 1'b0;
    dreq.dividend = nanos - last_nanos;
    unique case (state)
      ST_FIND, ST_SCAN, ST_HEAD: rd_en = idx < count;
      ST_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = IdxW'(idx - CntW'(1));
      end
      ST_SHIFT_WR: wr_en = 1'b1;
      ST_DROP_RD: begin
        rd_en   = 1'b1;
        rd_addr = IdxW'(idx + CntW'(1));
      end
      ST_DROP_WR: begin
        wr_en   = 1'b1;
        wr_wake = rd_wake;
        wr_task = rd_task;
      end
      ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos[IdxW-1:0];
      end
      ST_TICK: dreq.start = hpet_enable &&
          (tick_clock - last_recal_ms > 64'(recal_interval_ms));
      default: ;
    endcase
    if (state == ST_SHIFT_WR) begin
      wr_wake = rd_wake;
      wr_task = rd_task;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      clock_ms      <= '0;
      last_nanos    <= '0;
      last_recal_ms <= '0;
      res_put       <= 1'b0;
      idx           <= '0;
      after_tick    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            op      <= op_t'(s_tdata[1:0]);
            task_id <= s_tdata[17:2];
            wake    <= s_tdata[81:18];
            nanos   <= s_tdata[145:82];
            idx     <= '0;
            found   <= 1'b0;
            unique case (op_t'(s_tdata[1:0]))
              OP_INSERT: state <= ST_FIND;
              OP_UNWAIT, OP_QUERY: state <= ST_SCAN;
              OP_TICK: state <= ST_TICK;
              default: state <= ST_IDLE;
            endcase
          end
        end
        // read slot idx; data arrives next cycle in ST_FIND with flag
        ST_FIND: begin
          if (count == CntW'(CAPACITY)) begin
            res <= '{last: 1'b1, now_ms: clock_ms, queue_full: 1'b1,
                     timed_out: 1'b0, woken_task: '0, kind: KIND_ACK};
            res_put <= ~res_put;
            state   <= ST_IDLE;
          end else if (found && rd_wake > wake) begin
            // position is idx-1, shift tail from end
            pos   <= idx - CntW'(1);
            idx   <= count;
            found <= 1'b0;
            state <= (count > idx - CntW'(1)) ? ST_SHIFT_RD : ST_PUT;
          end else if (idx >= count) begin
            pos   <= count;
            state <= ST_PUT;
          end else begin
            found <= 1'b1;
            idx   <= idx + CntW'(1);
          end
        end
        ST_SHIFT_RD: state <= ST_SHIFT_WR;
        ST_SHIFT_WR: begin
          idx   <= idx - CntW'(1);
          state <= (idx - CntW'(1) > pos) ? ST_SHIFT_RD : ST_PUT;
        end
        ST_PUT: begin
          count <= count + CntW'(1);
          res <= '{last: 1'b1, now_ms: clock_ms, queue_full: 1'b0,
                   timed_out: 1'b0, woken_task: '0, kind: KIND_ACK};
          res_put <= ~res_put;
          state   <= ST_IDLE;
        end
        // found flags that rd data of idx-1 is valid
        ST_SCAN: begin
          if (found) begin
            found <= 1'b0;
            if (op == OP_UNWAIT && rd_task == task_id) begin
              idx   <= idx - CntW'(1);
              pos   <= idx - CntW'(1);
              state <= (idx < count) ? ST_DROP_RD : ST_DROP_WR;
            end else if (op == OP_QUERY && rd_task == task_id && clock_ms < rd_wake) begin
              res <= '{last: 1'b1, now_ms: clock_ms, queue_full: 1'b0,
                       timed_out: 1'b0, woken_task: '0, kind: KIND_QUERY};
              res_put <= ~res_put;
              state   <= ST_IDLE;
            end
          end else if (idx >= count) begin
            res <= '{last: 1'b1, now_ms: clock_ms, queue_full: 1'b0,
                     timed_out: op == OP_QUERY,  woken_task: '0,
                     kind: (op == OP_QUERY) ? KIND_QUERY : KIND_ACK};
            res_put <= ~res_put;
            state   <= ST_IDLE;
          end else begin
            found <= 1'b1;
            idx   <= idx + CntW'(1);
          end
        end
        // shift slots idx+1.. down by one, then shrink the list
        ST_DROP_RD: state <= ST_DROP_WR;
        ST_DROP_WR: begin
          if (idx + CntW'(1) < count - CntW'(1) || (idx + CntW'(1) < count && 1'b0)) begin
            idx   <= idx + CntW'(1);
            state <= ST_DROP_RD;
          end else begin
            count <= count - CntW'(1);
            idx   <= pos;
            found <= 1'b0;
            state <= after_tick ? ST_HEAD : ST_SCAN;
          end
        end
        ST_TICK: begin
          clock_ms   <= tick_clock;
          after_tick <= 1'b1;
          state      <= dreq.start ? ST_DIV : ST_HEAD;
          idx        <= '0;
        end
        ST_DIV: if (drsp.done) begin
          clock_ms      <= last_recal_ms + elapsed_ms;
          last_recal_ms <= last_recal_ms + elapsed_ms;
          last_nanos    <= nanos;
          state         <= ST_HEAD;
        end
        ST_HEAD: state <= ST_HEAD_CHK;
        ST_HEAD_CHK: begin
          if (!out_valid || m_tready) begin
            if (count != '0 && clock_ms >= rd_wake) begin
              res <= '{last: 1'b0, now_ms: clock_ms, queue_full: 1'b0,
                       timed_out: 1'b0, woken_task: rd_task, kind: KIND_WOKEN};
              res_put <= ~res_put;
              idx   <= '0;
              pos   <= '0;
              state <= (count > CntW'(1)) ? ST_DROP_RD : ST_DROP_WR;
            end else begin
              res <= '{last: 1'b1, now_ms: clock_ms, queue_full: 1'b0,
                       timed_out: 1'b0, woken_task: '0, kind: KIND_TICK};
              res_put    <= ~res_put;
              after_tick <= 1'b0;
              state      <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = res.last;
  assign m_tdata  = {4'b0, res.now_ms, res.queue_full, res.timed_out,
                     res.woken_task, res.kind};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(CAPACITY)) else $error("entry count overflow");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_IDLE) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid && $stable(res))
    else $error("result lost while stalled");

endmodule

// ===== bench/sorted_wake_timer_queue_chk.sv =====
module sorted_wake_timer_queue_chk
  import swtq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [151:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [87:0]  m_tdata,
  input  logic         m_tlast,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = 16;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] woken;
    logic        tmo;
    logic        full;
    logic [63:0] now;
    logic        last;
  } outcome_t;

  logic [63:0] wake_q [Slots];
  logic [15:0] task_q [Slots];
  int          count;
  logic [63:0] clk_ms, prev_nanos, recal_ms;
  logic [9:0]  tick_ms;
  logic [15:0] recal_ivl;
  logic        hpet_on;
  outcome_t    outcomes [$];

  function automatic outcome_t mk(kind_t k, logic [15:0] w, logic t, logic f, logic l);
    outcome_t o;
    o.kind = k; o.woken = w; o.tmo = t; o.full = f; o.now = clk_ms; o.last = l;
    return o;
  endfunction

  task automatic remove_at(int pos);
    for (int i = pos; i + 1 < count; i++) begin
      wake_q[i] = wake_q[i+1];
      task_q[i] = task_q[i+1];
    end
    count--;
  endtask

  task automatic schedule_item(logic [151:0] d);
    op_t         op;
    logic [15:0] tid;
    logic [63:0] wk, ns;
    int          pos;
    logic        tmo;
    op  = op_t'(d[1:0]);
    tid = d[17:2];
    wk  = d[81:18];
    ns  = d[145:82];
    case (op)
      OP_INSERT: begin
        if (count >= Slots) begin
          outcomes.push_back(mk(KIND_ACK, 0, 0, 1, 1));
        end else begin
          pos = 0;
          while (pos < count && wake_q[pos] <= wk) pos++;
          for (int i = count; i > pos; i--) begin
            wake_q[i] = wake_q[i-1];
            task_q[i] = task_q[i-1];
          end
          wake_q[pos] = wk;
          task_q[pos] = tid;
          count++;
          outcomes.push_back(mk(KIND_ACK, 0, 0, 0, 1));
        end
      end
      OP_UNWAIT: begin
        pos = 0;
        while (pos < count) begin
          if (task_q[pos] == tid) remove_at(pos);
          else pos++;
        end
        outcomes.push_back(mk(KIND_ACK, 0, 0, 0, 1));
      end
      OP_QUERY: begin
        tmo = 1;
        for (int i = 0; i < count; i++)
          if (task_q[i] == tid && clk_ms < wake_q[i]) tmo = 0;
        outcomes.push_back(mk(KIND_QUERY, 0, tmo, 0, 1));
      end
      default: begin
        clk_ms = clk_ms + 64'(tick_ms);
        if (hpet_on && (clk_ms - recal_ms) > 64'(recal_ivl)) begin
          clk_ms = recal_ms + (ns - prev_nanos) / 64'(NsPerMs);
          prev_nanos = ns;
          recal_ms = clk_ms;
        end
        while (count > 0 && clk_ms >= wake_q[0]) begin
          outcomes.push_back(mk(KIND_WOKEN, task_q[0], 0, 0, 0));
          remove_at(0);
        end
        outcomes.push_back(mk(KIND_TICK, 0, 0, 0, 1));
      end
    endcase
  endtask

  assign pending = outcomes.size();

  always @(posedge clk) begin
    outcome_t e, a;
    if (rst) begin
      count = 0; clk_ms = 0; prev_nanos = 0; recal_ms = 0;
      tick_ms = 1; recal_ivl = 1000; hpet_on = 0;
      outcomes.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MS_PER_TICK: tick_ms = cfg_data[9:0];
          REG_RECAL:       recal_ivl = cfg_data;
          REG_HPET_EN:     hpet_on = cfg_data[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        a.kind = kind_t'(m_tdata[1:0]); a.woken = m_tdata[17:2]; a.tmo = m_tdata[18];
        a.full = m_tdata[19]; a.now = m_tdata[83:20]; a.last = m_tlast;
        if (outcomes.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer %p", a);
          fail_count <= fail_count + 1;
        end else begin
          e = outcomes.pop_front();
          if (e !== a) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", e, a);
            fail_count <= fail_count + 1;
          end
        end
      end
      // result cannot leave in the same cycle its input is taken
      if (s_tvalid && s_tready) schedule_item(s_tdata);
    end
  end
endmodule

// ===== bench/sorted_wake_timer_queue_tb.sv =====
module sorted_wake_timer_queue_tb;
  import swtq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // index past the last register, writes to it are ignored
  localparam logic [1:0] RegNone = 2'd3;

  logic         clk = 0, rst = 1;
  logic         cfg_we = 0;
  logic [1:0]   cfg_index = 0;
  logic [15:0]  cfg_data = 0;
  logic         s_tvalid = 0, s_tready, m_tvalid, m_tready = 0, m_tlast;
  logic [151:0] s_tdata = 0;
  logic [87:0]  m_tdata;
  int           fail_count, pending;
  int           idle_cycles = 0;
  logic [63:0]  now_guess;

  always #5 clk = ~clk;

  sorted_wake_timer_queue u_dut (.*);
  sorted_wake_timer_queue_chk u_chk (.*);

  always begin
    int w;
    @(negedge clk);
    w = $urandom_range(0, 7);
    if (w != 0) begin
      m_tready <= 0;
      repeat (w) @(negedge clk);
    end
    m_tready <= 1;
    @(posedge clk);
    while (!m_tvalid) @(posedge clk);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_item(op_t op, logic [15:0] tid, logic [63:0] wk, logic [63:0] ns);
    @(negedge clk);
    repeat ($urandom_range(0, 7)) @(negedge clk);
    s_tdata <= {6'd0, ns, wk, tid, op};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid <= 0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] nanos;
    now_guess = 0;
    nanos = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, each opcode, full list, unknown unwait
    send_item(OP_QUERY, 16'hffff, '1, '1);
    send_item(OP_UNWAIT, 16'h1234, 0, 0);
    for (int i = 0; i < 17; i++)
      send_item(OP_INSERT, i[15:0] ^ 16'hffff, (i == 16) ? '1 : 64'(i % 5 + 2), 0);
    send_item(OP_QUERY, 16'hfffe, 0, 0);
    send_item(OP_TICK, 0, 0, '1);
    send_item(OP_TICK, 0, 0, 0);
    send_item(OP_UNWAIT, 16'h0000, 0, 0);
    drain();
    write_reg(REG_MS_PER_TICK, 16'hffff);
    write_reg(REG_RECAL, 0);
    write_reg(REG_HPET_EN, 1);
    write_reg(RegNone, 16'h5555);
    send_item(OP_TICK, 0, 0, 64'd5_000_000);
    send_item(OP_TICK, 0, 0, 64'd1_000);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_MS_PER_TICK, 1); write_reg(REG_RECAL, 16'hffff);
                 write_reg(REG_HPET_EN, 0); end
        1: begin write_reg(REG_MS_PER_TICK, 0); end
        2: begin write_reg(REG_MS_PER_TICK, 1000); write_reg(REG_HPET_EN, 1);
                 write_reg(REG_RECAL, 0); end
        default: begin
          write_reg(REG_MS_PER_TICK, 16'($urandom_range(1, 50)));
          write_reg(REG_RECAL, 16'($urandom_range(0, 200)));
          write_reg(REG_HPET_EN, 16'($urandom_range(0, 1)));
        end
      endcase
      for (int n = 0; n < 75; n++) begin
        int r;
        logic [15:0] tid;
        r = $urandom_range(0, 99);
        tid = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 7));
        nanos = nanos + 64'($urandom_range(0, 60_000_000));
        if (r < 40)
          send_item(OP_INSERT, tid, ($urandom_range(0, 9) == 0) ? rand64() :
                    now_guess + 64'($urandom_range(0, 300)), 0);
        else if (r < 50) send_item(OP_UNWAIT, tid, rand64(), rand64());
        else if (r < 62) send_item(OP_QUERY, tid, rand64(), rand64());
        else send_item(OP_TICK, tid, rand64(),
                       ($urandom_range(0, 19) == 0) ? rand64() : nanos);
        if (n == 40) drain();
        now_guess = now_guess + 64'($urandom_range(0, 40));
      end
      drain();
    end
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/swtq_pkg.sv
hw/rtl/swtq_div.sv
hw/rtl/sorted_wake_timer_queue.sv
bench/sorted_wake_timer_queue_chk.sv
bench/sorted_wake_timer_queue_tb.sv
